// ===== src/psri_pkg.sv =====
`timescale 1ns / 1ps

package psri_pkg;

    // Default table depth
    localparam int PSRI_TABLE_ENTRIES = 64;

    // Item kinds; the fourth code leaves the table unchanged
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [63:0] seq;
        logic [63:0] from_seq;
        logic [5:0]  position;
    } t_item;

    typedef struct packed {
        logic        found;
        logic [63:0] range_first;
        logic [63:0] range_last;
        logic [63:0] entry_key;
        logic [31:0] entry_records;
        logic [6:0]  entries_used;
        logic        complete;
        logic [31:0] dropped_count;
    } t_result;

    // One table entry, kept as a single memory word
    typedef struct packed {
        logic [63:0] key;
        logic [63:0] first;
        logic [63:0] last;
        logic [31:0] records;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_READ
    } t_state;

    // Operations of the datapath; all but OP_IDLE produce a result
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_NULL,
        OP_ADD_HIT,
        OP_ADD_NEW,
        OP_ADD_DROP,
        OP_LOOK_HIT,
        OP_READ_HIT
    } t_op;

    typedef struct packed {
        logic load;
        logic rd_scan;
        logic rd_pos;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       seq_zero;
        logic       pos_ok;
        logic       used_zero;
        logic       full;
        logic       more;
        logic       match;
        logic       last;
    } t_stat;

endpackage

// ===== src/psri_ctrl.sv =====
`timescale 1ns / 1ps

module psri_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  psri_pkg::t_stat i_stat,
    output psri_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import psri_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.rd_scan = 1'b0;
        o_cmd.rd_pos  = 1'b0;
        o_cmd.op      = OP_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_state = ST_IDLE;
                if (i_stat.kind == KIND_ADD && !i_stat.seq_zero) begin
                    if (i_stat.used_zero) begin
                        o_cmd.op = OP_ADD_NEW;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end else if (i_stat.kind == KIND_LOOKUP) begin
                    if (i_stat.used_zero) begin
                        o_cmd.op = OP_NULL;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end else if (i_stat.kind == KIND_READ && i_stat.pos_ok) begin
                    o_cmd.rd_pos = 1'b1;
                    n_state      = ST_READ;
                end else begin
                    o_cmd.op = OP_NULL;
                end
            end
            ST_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.op = (i_stat.kind == KIND_ADD) ? OP_ADD_HIT : OP_LOOK_HIT;
                    n_state  = ST_IDLE;
                end else if (i_stat.last) begin
                    if (i_stat.kind == KIND_ADD) begin
                        o_cmd.op = i_stat.full ? OP_ADD_DROP : OP_ADD_NEW;
                    end else begin
                        o_cmd.op = OP_NULL;
                    end
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.rd_scan = i_stat.more;
                end
            end
            ST_READ: begin
                o_cmd.op = OP_READ_HIT;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== src/psri_dpath.sv =====
`timescale 1ns / 1ps

module psri_dpath #(
    parameter int TABLE_ENTRIES = psri_pkg::PSRI_TABLE_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psri_pkg::t_item  i_item,
    input  psri_pkg::t_cmd   i_cmd,
    output psri_pkg::t_stat  o_stat,
    output psri_pkg::t_result o_result,
    output logic             o_strobe
);
    import psri_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_entry        r_mem [TABLE_ENTRIES];
    t_entry        r_rd;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_addr;
    t_item         r_req;
    logic [CW-1:0] r_scan;
    logic [CW-1:0] r_used;
    logic [CW-1:0] n_used;
    logic [31:0]   r_drop;
    logic [31:0]   n_drop;
    t_result       r_res;
    t_result       n_res;
    logic          r_strobe;
    logic          n_strobe;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    assign rd_en   = i_cmd.rd_scan | i_cmd.rd_pos;
    assign rd_addr = i_cmd.rd_pos ? IW'(r_req.position) : r_scan[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
        r_rd_addr <= rd_addr;
        if (i_cmd.load) begin
            r_req <= i_item;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_scan   <= '0;
            r_used   <= '0;
            r_drop   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (i_cmd.load) begin
                r_scan <= '0;
            end else if (i_cmd.rd_scan) begin
                r_scan <= r_scan + CW'(1);
            end
            r_used   <= n_used;
            r_drop   <= n_drop;
            r_strobe <= n_strobe;
        end
    end

    assign o_stat.kind      = r_req.kind;
    assign o_stat.seq_zero  = (r_req.seq == 64'd0);
    assign o_stat.pos_ok    = (32'(r_req.position) < 32'(r_used));
    assign o_stat.used_zero = (r_used == '0);
    assign o_stat.full      = (32'(r_used) >= 32'(TABLE_ENTRIES));
    assign o_stat.more      = (r_scan < r_used);
    assign o_stat.match     = r_rd_vld && (r_rd.key == r_req.key);
    assign o_stat.last      = r_rd_vld && ((CW'(r_rd_addr) + CW'(1)) == r_used);

    always_comb begin
        n_used   = r_used;
        n_drop   = r_drop;
        n_res    = r_res;
        n_strobe = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_rd_addr;
        wr_data  = r_rd;
        if (i_cmd.op != OP_IDLE) begin
            n_strobe = 1'b1;
            n_res    = '0;
        end
        case (i_cmd.op)
            OP_IDLE: begin
            end
            OP_NULL: begin
            end
            OP_ADD_HIT: begin
                wr_en        = 1'b1;
                wr_data.last = r_req.seq;
                if (r_rd.records != '1) begin
                    wr_data.records = r_rd.records + 32'd1;
                end
                n_res.found = 1'b1;
            end
            OP_ADD_NEW: begin
                wr_en           = 1'b1;
                wr_addr         = r_used[IW-1:0];
                wr_data.key     = r_req.key;
                wr_data.first   = r_req.seq;
                wr_data.last    = r_req.seq;
                wr_data.records = 32'd1;
                n_used          = r_used + CW'(1);
                n_res.found     = 1'b1;
            end
            OP_ADD_DROP: begin
                if (r_drop != '1) begin
                    n_drop = r_drop + 32'd1;
                end
            end
            OP_LOOK_HIT: begin
                n_res.found       = 1'b1;
                n_res.range_first = (r_req.from_seq < r_rd.first) ? r_rd.first
                                                                  : r_req.from_seq;
                n_res.range_last  = r_rd.last;
            end
            OP_READ_HIT: begin
                n_res.found         = 1'b1;
                n_res.range_first   = r_rd.first;
                n_res.range_last    = r_rd.last;
                n_res.entry_key     = r_rd.key;
                n_res.entry_records = r_rd.records;
            end
            default: begin
            end
        endcase
        if (i_cmd.op != OP_IDLE) begin
            n_res.entries_used  = 7'(n_used);
            n_res.complete      = (n_drop == 32'd0);
            n_res.dropped_count = n_drop;
        end
    end

    assign o_result = r_res;
    assign o_strobe = r_strobe;

endmodule

// ===== src/per_key_sequence_range_index_unit.sv =====
`timescale 1ns / 1ps

// Channel   Ports                         Transfer when
// -------   ---------------------------   ----------------------------------
// item in   start, busy, i_item           rising edge with start high, busy low
// result    o_strobe, o_result            rising edge ending the o_strobe cycle
//
// Add and lookup on a non-empty table scan one entry per cycle through the
// registered memory read port, ending at a hit or at the last used entry.
// An in-range read makes a single read of the given position; all else,
// empty-table add and lookup included, commits straight from dispatch.
// busy drops as o_strobe shows, so the next transfer can land on the result cycle.
// Synchronous active-low reset clears occupancy, drop count and control only;
// the receiver cannot stall, each result is shown for one cycle.

module per_key_sequence_range_index_unit #(
    parameter int TABLE_ENTRIES = psri_pkg::PSRI_TABLE_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  psri_pkg::t_item   i_item,
    output psri_pkg::t_result o_result,
    output logic              o_strobe
);
    import psri_pkg::*;

    // Command and status between the sequencer and the table datapath
    t_cmd  cmd;
    t_stat stat;

    // Sequencer: dispatch on kind, step the scan, pick the commit operation
    psri_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Datapath: hold the request, read and compare table entries, commit
    // updates and register the result
    psri_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

// ===== dv/per_key_sequence_range_index_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the per-key sequence range index.
// Runs a directed opening and then random bursts of add, lookup and read
// transfers. Every accepted transfer is predicted at once and checked in
// order against the strobed results.
module per_key_sequence_range_index_unit_tb;

    import psri_pkg::*;

    localparam int          DEPTH        = PSRI_TABLE_ENTRIES;
    localparam int          RANDOM_ITEMS = 500;
    // The package names three kinds; the fourth code must leave the table alone
    localparam logic [1:0]  KIND_NOP     = 2'd3;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    // Shadow copy of the table plus the queue of results still owed by the block.
    class range_index_scoreboard;
        logic [63:0] key_tab [DEPTH];
        logic [63:0] first_tab [DEPTH];
        logic [63:0] last_tab [DEPTH];
        logic [31:0] rec_tab [DEPTH];
        int          used;
        logic [31:0] drop_total;
        t_result     owed_q [$];
        int          errors;
        int          n_checked;
        int          n_add, n_add_new, n_add_hit, n_add_drop, n_add_zero;
        int          n_look, n_look_hit, n_read, n_read_hit, n_nop;

        function new();
            used       = 0;
            drop_total = '0;
            errors     = 0;
            n_checked  = 0;
            n_add      = 0;
            n_add_new  = 0;
            n_add_hit  = 0;
            n_add_drop = 0;
            n_add_zero = 0;
            n_look     = 0;
            n_look_hit = 0;
            n_read     = 0;
            n_read_hit = 0;
            n_nop      = 0;
        endfunction

        // Search in insertion order; -1 when the key is not held
        function int slot_of_key(logic [63:0] k);
            for (int s = 0; s < used; s++) begin
                if (key_tab[s] == k)
                    return s;
            end
            return -1;
        endfunction

        // Apply one transfer to the shadow table and work out its result
        function t_result predict_range(t_item it);
            t_result r;
            int      slot;
            r = '0;
            case (it.kind)
                KIND_ADD: begin
                    n_add++;
                    if (it.seq == '0) begin
                        n_add_zero++;
                    end else begin
                        slot = slot_of_key(it.key);
                        if (slot < 0 && used >= DEPTH) begin
                            n_add_drop++;
                            if (drop_total != 32'hFFFF_FFFF)
                                drop_total++;
                        end else begin
                            if (slot < 0) begin
                                n_add_new++;
                                slot            = used;
                                used++;
                                key_tab[slot]   = it.key;
                                first_tab[slot] = it.seq;
                                rec_tab[slot]   = '0;
                            end else begin
                                n_add_hit++;
                            end
                            last_tab[slot] = it.seq;
                            if (rec_tab[slot] != 32'hFFFF_FFFF)
                                rec_tab[slot]++;
                            r.found = 1'b1;
                        end
                    end
                end
                KIND_LOOKUP: begin
                    n_look++;
                    slot = slot_of_key(it.key);
                    if (slot >= 0) begin
                        n_look_hit++;
                        r.found       = 1'b1;
                        r.range_first = (it.from_seq < first_tab[slot]) ?
                                        first_tab[slot] : it.from_seq;
                        r.range_last  = last_tab[slot];
                    end
                end
                KIND_READ: begin
                    n_read++;
                    if (int'(it.position) < used) begin
                        n_read_hit++;
                        r.found         = 1'b1;
                        r.range_first   = first_tab[it.position];
                        r.range_last    = last_tab[it.position];
                        r.entry_key     = key_tab[it.position];
                        r.entry_records = rec_tab[it.position];
                    end
                end
                default: begin
                    n_nop++;
                end
            endcase
            r.entries_used  = 7'(used);
            r.complete      = (drop_total == '0);
            r.dropped_count = drop_total;
            return r;
        endfunction

        function void note_transfer(t_item it);
            owed_q.push_back(predict_range(it));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_q.size() == 0) begin
                $error("result strobe with no transfer outstanding");
                errors++;
                return;
            end
            want = owed_q.pop_front();
            n_checked++;
            compare_field("found", want.found, got.found);
            compare_field("range_first", want.range_first, got.range_first);
            compare_field("range_last", want.range_last, got.range_last);
            compare_field("entry_key", want.entry_key, got.entry_key);
            compare_field("entry_records", want.entry_records, got.entry_records);
            compare_field("entries_used", want.entries_used, got.entries_used);
            compare_field("complete", want.complete, got.complete);
            compare_field("dropped_count", want.dropped_count, got.dropped_count);
        endfunction
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    t_result o_result;
    logic    o_strobe;

    range_index_scoreboard sb;

    // Keys handed to the block so far; hits and lookups draw on these
    logic [63:0] known_keys [$];

    per_key_sequence_range_index_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Sample at the rising edge: check the strobed result first, since the next
    // transfer may be taken at the same edge that ends the result cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_result(o_result);
            if (start && !busy)
                sb.note_transfer(i_item);
        end
    end

    function automatic t_item mk_item(logic [1:0] kind, logic [63:0] key, logic [63:0] seq,
                                      logic [63:0] from_seq, logic [5:0] position);
        t_item it;
        it.kind     = kind;
        it.key      = key;
        it.seq      = seq;
        it.from_seq = from_seq;
        it.position = position;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly adds and lookups on keys already held, with a steady trickle of
    // fresh keys so the table fills part way through and then starts dropping.
    function automatic t_item make_random_item();
        t_item       it;
        int unsigned pick;
        it          = mk_item(KIND_NOP, rand64(), rand64(), rand64(), 6'($urandom));
        pick        = $urandom_range(0, 99);
        if (pick < 50)
            it.kind = KIND_ADD;
        else if (pick < 75)
            it.kind = KIND_LOOKUP;
        else if (pick < 95)
            it.kind = KIND_READ;

        // Vary the requested start: zero, all ones, small values or fully random
        case ($urandom_range(0, 3))
            0: it.from_seq = '0;
            1: it.from_seq = ALL_ONES;
            2: it.from_seq = 64'($urandom_range(0, 1000));
            default: ;
        endcase

        case (it.kind)
            KIND_ADD: begin
                if ($urandom_range(0, 19) == 0)
                    it.seq = '0;
                if (known_keys.size() > 0 && $urandom_range(0, 99) < 55)
                    it.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else if (it.seq != '0)
                    known_keys.push_back(it.key);
            end
            KIND_LOOKUP: begin
                if (known_keys.size() > 0 && $urandom_range(0, 3) != 0)
                    it.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            end
            KIND_READ: begin
                // Favour positions that are occupied, but keep probing beyond
                if ($urandom_range(0, 1) == 0)
                    it.position = 6'($urandom_range(0, known_keys.size() < DEPTH ?
                                                       known_keys.size() : DEPTH - 1));
            end
            default: ;
        endcase
        return it;
    endfunction

    // Call at a falling edge; hold start until the block takes the transfer and
    // return at the next falling edge with start still high.
    task automatic transfer_item(input t_item it);
        start  = 1'b1;
        i_item = it;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int gap;
        case ($urandom_range(0, 3))
            0: gap = 0;
            3: gap = $urandom_range(9, 80);
            default: gap = $urandom_range(1, 8);
        endcase
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    initial begin
        int sent;
        int burst;
        int drain;

        sb      = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed opening: empty table, zero sequence, no-op kind, first and
        // last extremes, hit with an older sequence, clamping both ways,
        // lookup miss and reads in and beyond the occupied range.
        transfer_item(mk_item(KIND_READ, '0, '0, '0, 6'd0));
        transfer_item(mk_item(KIND_LOOKUP, '0, '0, '0, 6'd0));
        transfer_item(mk_item(KIND_ADD, 64'd5, '0, '0, 6'd0));
        transfer_item(mk_item(KIND_NOP, '0, '0, '0, 6'd0));
        transfer_item(mk_item(KIND_ADD, '0, 64'd1, '0, 6'd0));
        transfer_item(mk_item(KIND_ADD, ALL_ONES, ALL_ONES, ALL_ONES, 6'd63));
        transfer_item(mk_item(KIND_ADD, '0, 64'd100, '0, 6'd0));
        transfer_item(mk_item(KIND_ADD, '0, 64'd7, '0, 6'd0));
        transfer_item(mk_item(KIND_LOOKUP, '0, '0, '0, 6'd0));
        transfer_item(mk_item(KIND_LOOKUP, '0, '0, ALL_ONES, 6'd0));
        transfer_item(mk_item(KIND_LOOKUP, ALL_ONES, '0, 64'd5, 6'd0));
        transfer_item(mk_item(KIND_LOOKUP, 64'h1234, '0, 64'd5, 6'd0));
        transfer_item(mk_item(KIND_ADD, 64'hA5A5_A5A5_5A5A_5A5A,
                              64'h8000_0000_0000_0000, '0, 6'd0));
        transfer_item(mk_item(KIND_ADD, ALL_ONES, '0, '0, 6'd0));
        transfer_item(mk_item(KIND_READ, '0, '0, '0, 6'd0));
        transfer_item(mk_item(KIND_READ, '0, '0, '0, 6'd1));
        transfer_item(mk_item(KIND_READ, '0, '0, '0, 6'd2));
        transfer_item(mk_item(KIND_READ, '0, '0, '0, 6'd3));
        transfer_item(mk_item(KIND_READ, ALL_ONES, ALL_ONES, ALL_ONES, 6'd63));
        transfer_item(mk_item(KIND_NOP, ALL_ONES, ALL_ONES, ALL_ONES, 6'd63));
        known_keys = '{64'h0, ALL_ONES, 64'hA5A5_A5A5_5A5A_5A5A};

        // Random bursts with idle gaps of varying length
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                transfer_item(make_random_item());
                sent++;
            end
            idle_gap();
        end
        start = 1'b0;

        // Drain what is still owed, then watch a full scan longer for strays
        drain = 0;
        while (sb.owed_q.size() > 0 && drain < 10 * (DEPTH + 8)) begin
            @(posedge i_clk);
            drain++;
        end
        if (sb.owed_q.size() > 0) begin
            $error("%0d results never arrived", sb.owed_q.size());
            sb.errors++;
        end
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("Checked %0d results: %0d adds (%0d new, %0d hits, %0d dropped, %0d zero seq)",
                 sb.n_checked, sb.n_add, sb.n_add_new, sb.n_add_hit, sb.n_add_drop,
                 sb.n_add_zero);
        $display("%0d lookups (%0d hits), %0d reads (%0d in range), %0d no-ops, %0d/%0d used",
                 sb.n_look, sb.n_look_hit, sb.n_read, sb.n_read_hit, sb.n_nop, sb.used, DEPTH);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
